// File: design/dcsp_pkg.sv
// Shared types, codes and the command type classifier for the DSI command sequence parser.
package dcsp_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_TRUNC = 2'd1,
    ERR_TYPE  = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_WAIT = 2'd1,
    PH_LEN  = 2'd2,
    PH_PAY  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CLS_GENERIC = 2'd0,
    CLS_DCS     = 2'd1,
    CLS_UNKNOWN = 2'd2
  } cls_t;

  localparam logic [7:0] TYPE_GEN_SHORT_0P = 8'h03;
  localparam logic [7:0] TYPE_GEN_SHORT_1P = 8'h13;
  localparam logic [7:0] TYPE_GEN_SHORT_2P = 8'h23;
  localparam logic [7:0] TYPE_GEN_LONG     = 8'h29;
  localparam logic [7:0] TYPE_DCS_SHORT_0P = 8'h05;
  localparam logic [7:0] TYPE_DCS_SHORT_1P = 8'h15;
  localparam logic [7:0] TYPE_DCS_LONG     = 8'h39;

  // Results caused by one input byte; emitted in order data, end, done, error.
  typedef struct packed {
    logic       has_data;
    logic       has_end;
    logic       has_done;
    err_t       err;
    logic [7:0] data;
    logic       is_dcs;
    logic [7:0] wait_ms;
  } rec_t;

  function automatic cls_t classify(input logic [7:0] t);
    cls_t c;
    unique case (t)
      TYPE_GEN_SHORT_0P,
      TYPE_GEN_SHORT_1P,
      TYPE_GEN_SHORT_2P,
      TYPE_GEN_LONG:     c = CLS_GENERIC;
      TYPE_DCS_SHORT_0P,
      TYPE_DCS_SHORT_1P,
      TYPE_DCS_LONG:     c = CLS_DCS;
      default:           c = CLS_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

// File: design/dcsp_front.sv
// Front end: tracks header and payload fields and builds one result record per byte.
module dcsp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  logic [7:0]    seq_byte,
  input  logic          blob_end,
  output logic          wr_en,
  output dcsp_pkg::rec_t wr_rec
);

  dcsp_pkg::phase_t phase, phase_next;
  logic             held_class, held_class_next;
  logic [7:0]       held_wait, held_wait_next;
  logic [7:0]       bytes_left, bytes_left_next;
  logic             dropping, dropping_next;
  dcsp_pkg::cls_t   cls;

  assign cls = dcsp_pkg::classify(seq_byte);

  // next state
  always_comb begin
    phase_next      = phase;
    held_class_next = held_class;
    held_wait_next  = held_wait;
    bytes_left_next = bytes_left;
    dropping_next   = dropping;
    if (!dropping) begin
      unique case (phase)
        dcsp_pkg::PH_WAIT: begin
          held_wait_next = seq_byte;
          phase_next     = dcsp_pkg::PH_LEN;
        end
        dcsp_pkg::PH_LEN: begin
          bytes_left_next = seq_byte;
          phase_next      = (seq_byte == 8'd0) ? dcsp_pkg::PH_TYPE : dcsp_pkg::PH_PAY;
        end
        dcsp_pkg::PH_PAY: begin
          bytes_left_next = bytes_left - 8'd1;
          if (bytes_left == 8'd1) begin
            phase_next = dcsp_pkg::PH_TYPE;
          end
        end
        dcsp_pkg::PH_TYPE: begin
          if (cls == dcsp_pkg::CLS_UNKNOWN) begin
            dropping_next = 1'b1;
          end else begin
            held_class_next = (cls == dcsp_pkg::CLS_DCS);
            phase_next      = dcsp_pkg::PH_WAIT;
          end
        end
      endcase
    end
    if (blob_end) begin
      phase_next      = dcsp_pkg::PH_TYPE;
      held_class_next = 1'b0;
      held_wait_next  = 8'd0;
      bytes_left_next = 8'd0;
      dropping_next   = 1'b0;
    end
  end

  // record for this byte
  always_comb begin
    wr_rec          = '0;
    wr_rec.err      = dcsp_pkg::ERR_NONE;
    wr_rec.is_dcs   = held_class;
    wr_rec.wait_ms  = held_wait;
    if (!dropping) begin
      unique case (phase)
        dcsp_pkg::PH_WAIT: begin
          if (blob_end) wr_rec.err = dcsp_pkg::ERR_TRUNC;
        end
        dcsp_pkg::PH_LEN: begin
          if (seq_byte == 8'd0) begin
            wr_rec.has_end  = 1'b1;
            wr_rec.has_done = blob_end;
          end else if (blob_end) begin
            wr_rec.err = dcsp_pkg::ERR_TRUNC;
          end
        end
        dcsp_pkg::PH_PAY: begin
          wr_rec.has_data = 1'b1;
          wr_rec.data     = seq_byte;
          if (bytes_left == 8'd1) begin
            wr_rec.has_end  = 1'b1;
            wr_rec.has_done = blob_end;
          end else if (blob_end) begin
            wr_rec.err = dcsp_pkg::ERR_TRUNC;
          end
        end
        dcsp_pkg::PH_TYPE: begin
          if (cls == dcsp_pkg::CLS_UNKNOWN) begin
            wr_rec.err = dcsp_pkg::ERR_TYPE;
          end else if (blob_end) begin
            wr_rec.err = dcsp_pkg::ERR_TRUNC;
          end
        end
      endcase
    end
  end

  assign wr_en = in_fire && !dropping &&
                 (wr_rec.has_data || wr_rec.has_end || (wr_rec.err != dcsp_pkg::ERR_NONE));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= dcsp_pkg::PH_TYPE;
      held_class <= 1'b0;
      held_wait  <= 8'd0;
      bytes_left <= 8'd0;
      dropping   <= 1'b0;
    end else if (in_fire) begin
      phase      <= phase_next;
      held_class <= held_class_next;
      held_wait  <= held_wait_next;
      bytes_left <= bytes_left_next;
      dropping   <= dropping_next;
    end
  end

endmodule

// File: design/dcsp_fifo.sv
// Short record queue between the front end and the result sequencer.
module dcsp_fifo #(
  parameter int unsigned DEPTH = dcsp_pkg::FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  dcsp_pkg::rec_t wr_rec,
  output logic           full,
  input  logic           rd_en,
  output dcsp_pkg::rec_t rd_rec,
  output logic           empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dcsp_pkg::rec_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_rec = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: design/dcsp_back.sv
// Back end: expands each queued record into its results, one transfer per cycle while pop stays high.
module dcsp_back (
  input  logic           clk,
  input  logic           rst,
  input  dcsp_pkg::rec_t rd_rec,
  input  logic           q_empty,
  output logic           rd_en,
  input  logic           pop,
  output logic           empty,
  output logic [1:0]     kind,
  output logic [7:0]     data_byte,
  output logic           is_dcs,
  output logic [7:0]     wait_ms,
  output logic [1:0]     error_code,
  output logic           run_last
);

  // pending results: bit 0 data, 1 end, 2 done, 3 error
  logic [3:0]     pend, pend_next, pend_after;
  dcsp_pkg::rec_t cur;
  logic           take, advance;

  assign pend_after = pend & (pend - 4'd1);
  assign empty      = (pend == 4'd0);
  assign take       = pop && !empty;
  assign advance    = empty || (take && (pend_after == 4'd0));
  assign rd_en      = advance && !q_empty;
  assign run_last   = (pend_after == 4'd0);

  always_comb begin
    if (advance) begin
      pend_next = q_empty ? 4'd0 :
                  {rd_rec.err != dcsp_pkg::ERR_NONE, rd_rec.has_done,
                   rd_rec.has_end, rd_rec.has_data};
    end else if (take) begin
      pend_next = pend_after;
    end else begin
      pend_next = pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 4'd0;
    end else begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur <= rd_rec;
    end
  end

  always_comb begin
    kind       = dcsp_pkg::KIND_DATA;
    data_byte  = 8'd0;
    is_dcs     = 1'b0;
    wait_ms    = 8'd0;
    error_code = dcsp_pkg::ERR_NONE;
    priority if (pend[0]) begin
      kind      = dcsp_pkg::KIND_DATA;
      data_byte = cur.data;
      is_dcs    = cur.is_dcs;
    end else if (pend[1]) begin
      kind    = dcsp_pkg::KIND_END;
      is_dcs  = cur.is_dcs;
      wait_ms = cur.wait_ms;
    end else if (pend[2]) begin
      kind = dcsp_pkg::KIND_DONE;
    end else if (pend[3]) begin
      kind       = dcsp_pkg::KIND_ERR;
      error_code = cur.err;
    end else begin
      kind = dcsp_pkg::KIND_DATA;
    end
  end

endmodule

// File: design/dsi_command_sequence_parser.sv
// Top level of the DSI panel command sequence parser.
//
// Input: a queue-style write side. One blob byte (seq_byte, blob_end on the
// final byte) transfers on each edge with push high and full low; one byte
// per cycle is sustained while the result side keeps up.
// Output: a queue-style read side. While empty is low the oldest result sits
// on kind, data_byte, is_dcs, wait_ms, error_code and run_last; it transfers
// on an edge with pop high. A byte yields zero to three results; the result
// side delivers one per cycle while pop is held high.
// Path: with both stages idle, the first result of a byte passes through the
// record queue and then the output register before it reaches the read side.
// Header bytes normally yield nothing; an unknown type reports an error and
// the remainder of the blob is discarded. A blob that ends mid-command
// reports a truncation error.
// When the reader stalls, results back up into a FIFO_DEPTH-entry record
// queue; full rises once it fills and input stops.
// Reset (rst, synchronous) empties both sides and expects a type byte.
module dsi_command_sequence_parser #(
  parameter int unsigned FIFO_DEPTH = dcsp_pkg::FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] seq_byte,
  input  logic       blob_end,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind,
  output logic [7:0] data_byte,
  output logic       is_dcs,
  output logic [7:0] wait_ms,
  output logic [1:0] error_code,
  output logic       run_last
);

  dcsp_pkg::rec_t wr_rec, rd_rec;
  logic           wr_en, rd_en, q_empty, in_fire;

  assign in_fire = push && !full;

  dcsp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .seq_byte (seq_byte),
    .blob_end (blob_end),
    .wr_en    (wr_en),
    .wr_rec   (wr_rec)
  );

  dcsp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (wr_en),
    .wr_rec (wr_rec),
    .full   (full),
    .rd_en  (rd_en),
    .rd_rec (rd_rec),
    .empty  (q_empty)
  );

  dcsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .rd_rec     (rd_rec),
    .q_empty    (q_empty),
    .rd_en      (rd_en),
    .pop        (pop),
    .empty      (empty),
    .kind       (kind),
    .data_byte  (data_byte),
    .is_dcs     (is_dcs),
    .wait_ms    (wait_ms),
    .error_code (error_code),
    .run_last   (run_last)
  );

`ifndef SYNTHESIS
  a_err_code_kind: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((kind == dcsp_pkg::KIND_ERR) == (error_code != dcsp_pkg::ERR_NONE)))
    else $error("error_code disagrees with kind");

  a_done_err_last: assert property (@(posedge clk) disable iff (rst)
    !empty && (kind == dcsp_pkg::KIND_DONE || kind == dcsp_pkg::KIND_ERR) |-> run_last)
    else $error("done or error result not marked last");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    !empty && kind != dcsp_pkg::KIND_DATA |-> data_byte == 8'd0)
    else $error("data_byte set on non-payload result");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(kind) && $stable(data_byte) && $stable(run_last))
    else $error("pending result changed while stalled");
`endif

endmodule

// File: verif/dsi_command_sequence_parser_check.sv
`timescale 1ns / 1ps
// Result checker for the DSI command sequence parser: predicts each transfer's results and compares.
module dsi_command_sequence_parser_check (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] seq_byte,
  input  logic       blob_end,
  input  logic       empty,
  input  logic       pop,
  input  logic [1:0] kind,
  input  logic [7:0] data_byte,
  input  logic       is_dcs,
  input  logic [7:0] wait_ms,
  input  logic [1:0] error_code,
  input  logic       run_last,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    dcsp_pkg::kind_t kind;
    logic [7:0]      data;
    logic            dcs;
    logic [7:0]      wait_ms;
    dcsp_pkg::err_t  err;
    logic            last;
  } parsed_t;

  dcsp_pkg::phase_t phase = dcsp_pkg::PH_TYPE;
  logic             cur_dcs = 1'b0;
  logic [7:0]       cur_wait = 8'h00;
  logic [7:0]       left = 8'h00;
  logic             dropping = 1'b0;
  parsed_t          parsed_q[$];
  int               fails = 0;

  function automatic dcsp_pkg::cls_t type_class(input logic [7:0] t);
    case (t)
      dcsp_pkg::TYPE_GEN_SHORT_0P,
      dcsp_pkg::TYPE_GEN_SHORT_1P,
      dcsp_pkg::TYPE_GEN_SHORT_2P,
      dcsp_pkg::TYPE_GEN_LONG: return dcsp_pkg::CLS_GENERIC;
      dcsp_pkg::TYPE_DCS_SHORT_0P,
      dcsp_pkg::TYPE_DCS_SHORT_1P,
      dcsp_pkg::TYPE_DCS_LONG: return dcsp_pkg::CLS_DCS;
      default: return dcsp_pkg::CLS_UNKNOWN;
    endcase
  endfunction

  function automatic parsed_t result_of(input dcsp_pkg::kind_t k, input logic [7:0] d,
                                        input logic c, input logic [7:0] w,
                                        input dcsp_pkg::err_t e);
    parsed_t r;
    r.kind = k;
    r.data = d;
    r.dcs = c;
    r.wait_ms = w;
    r.err = e;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void clear_parser();
    phase = dcsp_pkg::PH_TYPE;
    cur_dcs = 1'b0;
    cur_wait = 8'h00;
    left = 8'h00;
    dropping = 1'b0;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic last);
    parsed_t batch[$];
    parsed_t r;
    dcsp_pkg::cls_t c;
    if (dropping) begin
      if (last) clear_parser();
      return;
    end
    case (phase)
      dcsp_pkg::PH_WAIT: begin
        cur_wait = b;
        phase = dcsp_pkg::PH_LEN;
        if (last)
          batch.push_back(result_of(dcsp_pkg::KIND_ERR, 8'h00, 1'b0, 8'h00,
                                    dcsp_pkg::ERR_TRUNC));
      end
      dcsp_pkg::PH_LEN: begin
        left = b;
        if (b == 8'h00) begin
          batch.push_back(result_of(dcsp_pkg::KIND_END, 8'h00, cur_dcs, cur_wait,
                                    dcsp_pkg::ERR_NONE));
          phase = dcsp_pkg::PH_TYPE;
          if (last)
            batch.push_back(result_of(dcsp_pkg::KIND_DONE, 8'h00, 1'b0, 8'h00,
                                      dcsp_pkg::ERR_NONE));
        end else begin
          phase = dcsp_pkg::PH_PAY;
          if (last)
            batch.push_back(result_of(dcsp_pkg::KIND_ERR, 8'h00, 1'b0, 8'h00,
                                      dcsp_pkg::ERR_TRUNC));
        end
      end
      dcsp_pkg::PH_PAY: begin
        batch.push_back(result_of(dcsp_pkg::KIND_DATA, b, cur_dcs, 8'h00,
                                  dcsp_pkg::ERR_NONE));
        left = left - 8'd1;
        if (left == 8'h00) begin
          batch.push_back(result_of(dcsp_pkg::KIND_END, 8'h00, cur_dcs, cur_wait,
                                    dcsp_pkg::ERR_NONE));
          phase = dcsp_pkg::PH_TYPE;
          if (last)
            batch.push_back(result_of(dcsp_pkg::KIND_DONE, 8'h00, 1'b0, 8'h00,
                                      dcsp_pkg::ERR_NONE));
        end else if (last) begin
          batch.push_back(result_of(dcsp_pkg::KIND_ERR, 8'h00, 1'b0, 8'h00,
                                    dcsp_pkg::ERR_TRUNC));
        end
      end
      default: begin
        c = type_class(b);
        if (c == dcsp_pkg::CLS_UNKNOWN) begin
          batch.push_back(result_of(dcsp_pkg::KIND_ERR, 8'h00, 1'b0, 8'h00,
                                    dcsp_pkg::ERR_TYPE));
          dropping = 1'b1;
        end else begin
          cur_dcs = (c == dcsp_pkg::CLS_DCS);
          phase = dcsp_pkg::PH_WAIT;
          if (last)
            batch.push_back(result_of(dcsp_pkg::KIND_ERR, 8'h00, 1'b0, 8'h00,
                                      dcsp_pkg::ERR_TRUNC));
        end
      end
    endcase
    if (batch.size() > 0) begin
      r = batch.pop_back();
      if (r.kind == dcsp_pkg::KIND_ERR) dropping = 1'b1;
      r.last = 1'b1;
      batch.push_back(r);
    end
    if (last) clear_parser();
    foreach (batch[i]) parsed_q.push_back(batch[i]);
  endfunction

  always @(posedge clk) begin : watch
    parsed_t want;
    if (rst) begin
      clear_parser();
      parsed_q.delete();
    end else begin
      if (pop && !empty) begin
        if (parsed_q.size() == 0) begin
          fails++;
          $display("%0t unexpected result: expected none, actual kind=%0d data=%02h",
                   $time, kind, data_byte);
          $display("  dcs=%0d wait=%02h err=%0d last=%0d",
                   is_dcs, wait_ms, error_code, run_last);
        end else begin
          want = parsed_q.pop_front();
          if (kind !== want.kind || data_byte !== want.data || is_dcs !== want.dcs ||
              wait_ms !== want.wait_ms || error_code !== want.err ||
              run_last !== want.last) begin
            fails++;
            $display("%0t mismatch: expected kind=%0d data=%02h dcs=%0d wait=%02h err=%0d last=%0d",
                     $time, want.kind, want.data, want.dcs, want.wait_ms, want.err,
                     want.last);
            $display("  actual kind=%0d data=%02h dcs=%0d wait=%02h err=%0d last=%0d",
                     kind, data_byte, is_dcs, wait_ms, error_code, run_last);
          end
        end
      end
      if (push && !full) parse_byte(seq_byte, blob_end);
    end
    fail_count <= fails;
    pending <= parsed_q.size();
  end

endmodule

// File: verif/dsi_command_sequence_parser_test.sv
`timescale 1ns / 1ps
// Testbench top for the DSI command sequence parser: blob stimulus, flow control and verdict.
module dsi_command_sequence_parser_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 8;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] seq_byte = 8'h00;
  logic       blob_end = 1'b0;
  logic       pop = 1'b0;
  wire        full;
  wire        empty;
  wire  [1:0] kind;
  wire  [7:0] data_byte;
  wire        is_dcs;
  wire  [7:0] wait_ms;
  wire  [1:0] error_code;
  wire        run_last;
  int         fail_count;
  int         pending;

  int         cycles = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         hold_req = 0;
  int         sent = 0;
  logic [7:0] blob_bytes[$];

  always #2 clk = ~clk;

  dsi_command_sequence_parser uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .seq_byte(seq_byte),
    .blob_end(blob_end), .empty(empty), .pop(pop), .kind(kind), .data_byte(data_byte),
    .is_dcs(is_dcs), .wait_ms(wait_ms), .error_code(error_code), .run_last(run_last)
  );

  dsi_command_sequence_parser_check parse_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .seq_byte(seq_byte),
    .blob_end(blob_end), .empty(empty), .pop(pop), .kind(kind), .data_byte(data_byte),
    .is_dcs(is_dcs), .wait_ms(wait_ms), .error_code(error_code), .run_last(run_last),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[dsi_command_sequence_parser] ERROR");
      $finish;
    end
  end

  // Reader: random stalls, plus a long hold-off each time one is requested.
  initial begin : reader
    int served;
    served = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_req > served) begin
        served++;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    push <= 1'b1;
    seq_byte <= b;
    blob_end <= last;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_blob();
    for (int i = 0; i < blob_bytes.size(); i++)
      send_byte(blob_bytes[i], i == blob_bytes.size() - 1);
    sent += blob_bytes.size();
    blob_bytes.delete();
  endtask

  function automatic logic [7:0] valid_type();
    case ($urandom_range(6))
      0: return dcsp_pkg::TYPE_GEN_SHORT_0P;
      1: return dcsp_pkg::TYPE_GEN_SHORT_1P;
      2: return dcsp_pkg::TYPE_GEN_SHORT_2P;
      3: return dcsp_pkg::TYPE_GEN_LONG;
      4: return dcsp_pkg::TYPE_DCS_SHORT_0P;
      5: return dcsp_pkg::TYPE_DCS_SHORT_1P;
      default: return dcsp_pkg::TYPE_DCS_LONG;
    endcase
  endfunction

  function automatic int pick_len();
    int p;
    p = $urandom_range(99);
    if (p < 12) return 0;
    if (p < 82) return $urandom_range(6, 1);
    return $urandom_range(40, 7);
  endfunction

  function automatic void add_command(input int len);
    blob_bytes.push_back(valid_type());
    blob_bytes.push_back(8'($urandom_range(255)));
    blob_bytes.push_back(8'(len));
    repeat (len) blob_bytes.push_back(8'($urandom_range(255)));
  endfunction

  // Mostly well-formed blobs; some cut short, some with a bad type, some raw noise.
  function automatic void random_blob();
    int p;
    int keep;
    p = $urandom_range(99);
    if (p < 78) begin
      repeat ($urandom_range(4, 1)) add_command(pick_len());
      if (p >= 60 && blob_bytes.size() > 1) begin
        keep = $urandom_range(blob_bytes.size() - 1, 1);
        while (blob_bytes.size() > keep) void'(blob_bytes.pop_back());
      end
    end else if (p < 90) begin
      if ($urandom_range(1)) add_command(pick_len());
      blob_bytes.push_back(8'($urandom_range(255)));
      repeat ($urandom_range(3)) blob_bytes.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(4, 1)) blob_bytes.push_back(8'($urandom_range(255)));
    end
  endfunction

  initial begin : stimulus
    int start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // zero-length command, then a payload ending exactly on the final byte
    blob_bytes = '{dcsp_pkg::TYPE_GEN_SHORT_0P, 8'hFF, 8'h00,
                   dcsp_pkg::TYPE_DCS_LONG, 8'h00, 8'h01, 8'hFF};
    send_blob();
    // truncation in each header field and inside the payload, then a complete zero-length command
    blob_bytes = '{dcsp_pkg::TYPE_GEN_SHORT_1P};
    send_blob();
    blob_bytes = '{dcsp_pkg::TYPE_GEN_SHORT_2P, 8'h55};
    send_blob();
    blob_bytes = '{dcsp_pkg::TYPE_GEN_LONG, 8'h01, 8'h02};
    send_blob();
    blob_bytes = '{dcsp_pkg::TYPE_DCS_SHORT_0P, 8'h02, 8'h02, 8'hAA};
    send_blob();
    blob_bytes = '{dcsp_pkg::TYPE_DCS_SHORT_1P, 8'h03, 8'h00};
    send_blob();
    // unknown type on the final byte, then unknown type with a dropped tail
    blob_bytes = '{8'h7F};
    send_blob();
    blob_bytes = '{8'h00, 8'h11, 8'h22};
    send_blob();

    for (int ph = 0; ph < 5; ph++) begin
      start = sent;
      case (ph)
        0: begin idle_pct = 0; stall_pct <= 0; end
        1: begin idle_pct = 63; stall_pct <= 0; end
        2: begin idle_pct = 0; stall_pct <= 63; end
        3: begin idle_pct = 25; stall_pct <= 25; end
        default: begin
          idle_pct = 0;
          stall_pct <= 0;
          hold_req <= hold_req + 1;
        end
      endcase
      if (ph == 0) begin
        add_command($urandom_range(104, 100));
        send_blob();
      end
      if (ph == 4) begin
        add_command(12);
        send_blob();
      end
      while (sent - start < PHASE_ITEMS) begin
        random_blob();
        send_blob();
      end
    end

    push <= 1'b0;
    stall_pct <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[dsi_command_sequence_parser] OK");
    else
      $display("[dsi_command_sequence_parser] ERROR");
    $finish;
  end

endmodule
